// ----- rtl/hpt_pkg.sv -----
package hpt_pkg;

    localparam int PAGE_W    = 40;
    localparam int HOT_W     = 32;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int RCOUNT_W  = 7;
    localparam int RANK_W    = 6;
    localparam int SIZE_W    = 7;

    // most entries a single read returns
    localparam int MAX_RESULTS = 16;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECTED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic [HOT_W-1:0]  hot;
    } entry_t;

    typedef struct packed {
        logic page_match;
        logic not_hotter;
    } cmp_t;

endpackage

// ----- rtl/hpt_store.sv -----
module hpt_store #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  hpt_pkg::entry_t     wr_entry,
    input  logic                rd_en,
    input  logic [IDX_W-1:0]    rd_addr,
    output hpt_pkg::entry_t     rd_entry
);
    import hpt_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_entry_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

// ----- rtl/hpt_cmp.sv -----
module hpt_cmp (
    input  hpt_pkg::entry_t                 stored,
    input  logic [hpt_pkg::PAGE_W-1:0]      key_page,
    input  logic [hpt_pkg::HOT_W-1:0]       key_hot,
    output hpt_pkg::cmp_t                   result
);
    import hpt_pkg::*;

    // shared compare used by every insert and delete scan step
    always_comb
    begin
        result.page_match = (stored.page == key_page);
        result.not_hotter = (stored.hot <= key_hot);
    end

endmodule

// ----- rtl/hot_page_top_n_tracker.sv -----
// hot page top-n tracker
// keeps up to CAPACITY pages sorted by stored hotness, hottest at rank 0
// input channel (in_valid / in_ready): one command per transfer
//   insert, delete, update (delete then insert) or read of the top entries
// output channel (out_valid / out_ready): one result per insert, delete or
//   update; a read gives one result per entry returned (at most 16), or a
//   single empty result, with last set on the final one
// the block works on one command at a time; in_ready is high only when idle
// the scan steps one table entry a cycle through the single read port of the
//   table memory and, for insert and delete, the shared compare unit
// a result sits in an output register; a stalled receiver holds a read's scan
//   and the final result of any other command until the register is taken,
//   nothing is lost or repeated
// reset empties the table (fill count to zero); table contents are never
//   used beyond the fill count, so the memory needs no clearing pass
module hot_page_top_n_tracker #(
    parameter int CAPACITY = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [hpt_pkg::CMD_W-1:0]         command,
    input  logic [hpt_pkg::PAGE_W-1:0]        page_id,
    input  logic [hpt_pkg::HOT_W-1:0]         hotness,
    input  logic [hpt_pkg::RCOUNT_W-1:0]      read_count,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [hpt_pkg::STATUS_W-1:0]      status,
    output logic                              evicted_valid,
    output logic [hpt_pkg::PAGE_W-1:0]        evicted_page,
    output logic                              entry_valid,
    output logic [hpt_pkg::RANK_W-1:0]        entry_rank,
    output logic [hpt_pkg::PAGE_W-1:0]        entry_page,
    output logic [hpt_pkg::HOT_W-1:0]         entry_hotness,
    output logic [hpt_pkg::SIZE_W-1:0]        table_size,
    output logic                              last
);
    import hpt_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_INS_ISSUE = 3'd1;
    localparam logic [2:0] S_INS       = 3'd2;
    localparam logic [2:0] S_INS_PUT   = 3'd3;
    localparam logic [2:0] S_DEL       = 3'd4;
    localparam logic [2:0] S_READ      = 3'd5;
    localparam logic [2:0] S_RESULT    = 3'd6;

    logic [2:0]           state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic                 found_reg, found_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic                 ev_valid_reg, ev_valid_next;
    logic [PAGE_W-1:0]    ev_page_reg, ev_page_next;

    // latched command
    logic [CMD_W-1:0]     cmd_reg;
    logic [PAGE_W-1:0]    page_reg;
    logic [HOT_W-1:0]     hot_reg;
    logic [RCOUNT_W-1:0]  last_idx_reg, last_idx_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic                 out_load;
    logic [STATUS_W-1:0]  o_status_reg, o_status_next;
    logic                 o_ev_valid_reg, o_ev_valid_next;
    logic [PAGE_W-1:0]    o_ev_page_reg, o_ev_page_next;
    logic                 o_en_valid_reg, o_en_valid_next;
    logic [RANK_W-1:0]    o_rank_reg, o_rank_next;
    logic [PAGE_W-1:0]    o_en_page_reg, o_en_page_next;
    logic [HOT_W-1:0]     o_en_hot_reg, o_en_hot_next;
    logic [SIZE_W-1:0]    o_size_reg, o_size_next;
    logic                 o_last_reg, o_last_next;

    // table memory ports
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    entry_t               wr_entry;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    entry_t               rd_entry;
    cmp_t                 cmp;

    logic                 accept;
    logic                 out_free;
    logic                 full;
    logic [IDX_W-1:0]     fill_top;
    logic [IDX_W-1:0]     cap_top;
    logic                 del_hit;
    logic [RCOUNT_W-1:0]  fill_ext;
    logic [RCOUNT_W-1:0]  n_fill;
    logic [RCOUNT_W-1:0]  n_read;
    entry_t               new_entry;

    hpt_store #(
        .DEPTH (CAPACITY),
        .IDX_W (IDX_W)
    ) u_store (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry)
    );

    hpt_cmp u_cmp (
        .stored   (rd_entry),
        .key_page (page_reg),
        .key_hot  (hot_reg),
        .result   (cmp)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign full      = (fill_reg == CNT_W'(CAPACITY));
    assign fill_top  = IDX_W'(fill_reg - CNT_W'(1));
    assign cap_top   = IDX_W'(CAPACITY - 1);
    assign del_hit   = found_reg || cmp.page_match;
    assign new_entry = '{page: page_reg, hot: hot_reg};

    // entries a read returns: min(read_count, fill, result limit)
    assign fill_ext = RCOUNT_W'(fill_reg);
    assign n_fill   = (read_count < fill_ext) ? read_count : fill_ext;
    assign n_read   = (n_fill < RCOUNT_W'(MAX_RESULTS)) ? n_fill : RCOUNT_W'(MAX_RESULTS);

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        fill_next     = fill_reg;
        found_next    = found_reg;
        status_next   = status_reg;
        ev_valid_next = ev_valid_reg;
        ev_page_next  = ev_page_reg;
        last_idx_next = last_idx_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_entry      = rd_entry;
        out_load      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                // rank 0 is fetched ahead for delete, update and read
                rd_en = 1'b1;
                if (accept)
                begin
                    idx_next      = '0;
                    found_next    = 1'b0;
                    status_next   = ST_DONE;
                    ev_valid_next = 1'b0;
                    ev_page_next  = '0;
                    last_idx_next = n_read - RCOUNT_W'(1);
                    case (command)
                        CMD_READ:
                        begin
                            state_next = (n_read == '0) ? S_RESULT : S_READ;
                        end
                        CMD_INSERT:
                        begin
                            state_next = S_INS_ISSUE;
                        end
                        default:
                        begin
                            if (fill_reg == '0)
                            begin
                                status_next = ST_NOT_FOUND;
                                state_next  = S_RESULT;
                            end
                            else
                            begin
                                state_next = S_DEL;
                            end
                        end
                    endcase
                end
            end

            S_INS_ISSUE:
            begin
                if (fill_reg == '0)
                begin
                    wr_en      = 1'b1;
                    wr_entry   = new_entry;
                    fill_next  = fill_reg + CNT_W'(1);
                    state_next = S_RESULT;
                end
                else
                begin
                    // scan upward from the coldest entry
                    rd_en      = 1'b1;
                    rd_addr    = fill_top;
                    idx_next   = fill_top;
                    state_next = S_INS;
                end
            end

            S_INS:
            begin
                if (full && idx_reg == cap_top)
                begin
                    // coldest entry of a full table decides reject or evict
                    if (!cmp.not_hotter)
                    begin
                        status_next = ST_REJECTED;
                        state_next  = S_RESULT;
                    end
                    else
                    begin
                        ev_valid_next = 1'b1;
                        ev_page_next  = rd_entry.page;
                        if (idx_reg == '0)
                        begin
                            wr_en      = 1'b1;
                            wr_entry   = new_entry;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            rd_en    = 1'b1;
                            rd_addr  = idx_reg - IDX_W'(1);
                            idx_next = idx_reg - IDX_W'(1);
                        end
                    end
                end
                else if (cmp.not_hotter)
                begin
                    // entry moves one rank down
                    wr_en   = 1'b1;
                    wr_addr = idx_reg + IDX_W'(1);
                    if (idx_reg == '0)
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg - IDX_W'(1);
                        idx_next = idx_reg - IDX_W'(1);
                    end
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = idx_reg + IDX_W'(1);
                    wr_entry   = new_entry;
                    state_next = S_RESULT;
                    if (!full)
                    begin
                        fill_next = fill_reg + CNT_W'(1);
                    end
                end
            end

            S_INS_PUT:
            begin
                wr_en      = 1'b1;
                wr_entry   = new_entry;
                state_next = S_RESULT;
                if (!full)
                begin
                    fill_next = fill_reg + CNT_W'(1);
                end
            end

            S_DEL:
            begin
                // after the hit every entry moves one rank up
                if (found_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg - IDX_W'(1);
                end
                else if (cmp.page_match)
                begin
                    found_next = 1'b1;
                end

                if (idx_reg == fill_top)
                begin
                    if (del_hit)
                    begin
                        fill_next  = fill_reg - CNT_W'(1);
                        state_next = (cmd_reg == CMD_UPDATE) ? S_INS_ISSUE : S_RESULT;
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_RESULT;
                    end
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + IDX_W'(1);
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_READ:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (RCOUNT_W'(idx_reg) == last_idx_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + IDX_W'(1);
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end

            S_RESULT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // next contents of the output register
    always_comb
    begin
        if (state_reg == S_READ)
        begin
            o_status_next   = ST_DONE;
            o_ev_valid_next = 1'b0;
            o_ev_page_next  = '0;
            o_en_valid_next = 1'b1;
            o_rank_next     = RANK_W'(idx_reg);
            o_en_page_next  = rd_entry.page;
            o_en_hot_next   = rd_entry.hot;
            o_last_next     = (RCOUNT_W'(idx_reg) == last_idx_reg);
        end
        else
        begin
            o_status_next   = status_reg;
            o_ev_valid_next = ev_valid_reg;
            o_ev_page_next  = ev_valid_reg ? ev_page_reg : '0;
            o_en_valid_next = 1'b0;
            o_rank_next     = '0;
            o_en_page_next  = '0;
            o_en_hot_next   = '0;
            o_last_next     = 1'b1;
        end
        o_size_next = SIZE_W'(fill_reg);

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            fill_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            fill_reg      <= fill_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        ev_valid_reg <= ev_valid_next;
        ev_page_reg  <= ev_page_next;
        last_idx_reg <= last_idx_next;
        if (accept)
        begin
            cmd_reg  <= command;
            page_reg <= page_id;
            hot_reg  <= hotness;
        end
        if (out_load)
        begin
            o_status_reg   <= o_status_next;
            o_ev_valid_reg <= o_ev_valid_next;
            o_ev_page_reg  <= o_ev_page_next;
            o_en_valid_reg <= o_en_valid_next;
            o_rank_reg     <= o_rank_next;
            o_en_page_reg  <= o_en_page_next;
            o_en_hot_reg   <= o_en_hot_next;
            o_size_reg     <= o_size_next;
            o_last_reg     <= o_last_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = o_status_reg;
    assign evicted_valid = o_ev_valid_reg;
    assign evicted_page  = o_ev_page_reg;
    assign entry_valid   = o_en_valid_reg;
    assign entry_rank    = o_rank_reg;
    assign entry_page    = o_en_page_reg;
    assign entry_hotness = o_en_hot_reg;
    assign table_size    = o_size_reg;
    assign last          = o_last_reg;

endmodule

// ----- test/tb_hot_page_top_n_tracker.sv -----
`timescale 1ns / 1ps

module tb_hot_page_top_n_tracker;

    import hpt_pkg::*;

    localparam int TBL_DEPTH   = 16;
    localparam int POOL_SIZE   = 24;
    // worst case: 16 results per command, each behind a long receiver stall
    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_WAIT  = 64;

    // one result as the block should present it
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                evicted_valid;
        logic [PAGE_W-1:0]   evicted_page;
        logic                entry_valid;
        logic [RANK_W-1:0]   entry_rank;
        logic [PAGE_W-1:0]   entry_page;
        logic [HOT_W-1:0]    entry_hotness;
        logic [SIZE_W-1:0]   table_size;
        logic                last;
    } tracker_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [CMD_W-1:0]    command = CMD_INSERT;
    logic [PAGE_W-1:0]   page_id = '0;
    logic [HOT_W-1:0]    hotness = '0;
    logic [RCOUNT_W-1:0] read_count = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic                evicted_valid;
    logic [PAGE_W-1:0]   evicted_page;
    logic                entry_valid;
    logic [RANK_W-1:0]   entry_rank;
    logic [PAGE_W-1:0]   entry_page;
    logic [HOT_W-1:0]    entry_hotness;
    logic [SIZE_W-1:0]   table_size;
    logic                last;

    // shadow copy of the ranked page list, hottest at index 0
    logic [PAGE_W-1:0]   shadow_page [TBL_DEPTH];
    logic [HOT_W-1:0]    shadow_hot  [TBL_DEPTH];
    int                  shadow_count = 0;

    // results owed by the block, oldest first
    tracker_result_t     expected_results [$];

    logic [PAGE_W-1:0]   page_pool [POOL_SIZE];
    logic [PAGE_W-1:0]   dup_page;
    bit                  no_idle = 1'b0;
    int                  ready_hold = 0;
    int                  mismatch_count = 0;
    int                  cycle_count = 0;

    hot_page_top_n_tracker #(
        .CAPACITY(TBL_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .page_id(page_id),
        .hotness(hotness),
        .read_count(read_count),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .evicted_valid(evicted_valid),
        .evicted_page(evicted_page),
        .entry_valid(entry_valid),
        .entry_rank(entry_rank),
        .entry_page(entry_page),
        .entry_hotness(entry_hotness),
        .table_size(table_size),
        .last(last)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [PAGE_W-1:0] rand_page();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[PAGE_W-1:0];
    endfunction

    // small values for ties, the extremes, and values around the coldest entry
    function automatic logic [HOT_W-1:0] rand_hot();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return HOT_W'($urandom_range(0, 15));
        if (r < 45)
            return '0;
        if (r < 55)
            return '1;
        if (r < 70 && shadow_count > 0)
            return shadow_hot[shadow_count-1] + HOT_W'($urandom_range(0, 2)) - 1;
        return $urandom;
    endfunction

    function automatic logic [RCOUNT_W-1:0] rand_read_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return RCOUNT_W'($urandom_range(0, 3));
        if (r < 55)
            return RCOUNT_W'($urandom_range(4, 20));
        if (r < 65)
            return RCOUNT_W'(64);
        return RCOUNT_W'($urandom_range(0, 64));
    endfunction

    // ranked insert: goes ahead of the first entry not hotter than it
    task automatic shadow_insert(
        input  logic [PAGE_W-1:0]   page,
        input  logic [HOT_W-1:0]    hot,
        output logic [STATUS_W-1:0] st,
        output logic                ev_valid,
        output logic [PAGE_W-1:0]   ev_page
    );
        int pos;
        int top;
        int i;
        st = ST_DONE;
        ev_valid = 1'b0;
        ev_page = '0;
        if (shadow_count >= TBL_DEPTH)
        begin
            // full: colder than the tail bounces, otherwise the tail leaves
            if (hot < shadow_hot[TBL_DEPTH-1])
            begin
                st = ST_REJECTED;
                return;
            end
            ev_valid = 1'b1;
            ev_page = shadow_page[TBL_DEPTH-1];
        end
        pos = 0;
        while (pos < shadow_count && shadow_hot[pos] > hot)
            pos++;
        top = (shadow_count < TBL_DEPTH) ? shadow_count : TBL_DEPTH - 1;
        for (i = top; i > pos; i--)
        begin
            shadow_page[i] = shadow_page[i-1];
            shadow_hot[i] = shadow_hot[i-1];
        end
        shadow_page[pos] = page;
        shadow_hot[pos] = hot;
        if (shadow_count < TBL_DEPTH)
            shadow_count++;
    endtask

    // removes the hottest entry holding the page
    task automatic shadow_remove(input logic [PAGE_W-1:0] page, output logic found);
        int i;
        int j;
        found = 1'b0;
        for (i = 0; i < shadow_count; i++)
        begin
            if (shadow_page[i] == page)
            begin
                for (j = i; j + 1 < shadow_count; j++)
                begin
                    shadow_page[j] = shadow_page[j+1];
                    shadow_hot[j] = shadow_hot[j+1];
                end
                shadow_count--;
                found = 1'b1;
                return;
            end
        end
    endtask

    // queues the results one accepted command should cause
    task automatic predict_command(
        input logic [CMD_W-1:0]    cmd,
        input logic [PAGE_W-1:0]   page,
        input logic [HOT_W-1:0]    hot,
        input logic [RCOUNT_W-1:0] cnt
    );
        tracker_result_t     r;
        int                  n;
        int                  k;
        logic                found;
        logic [STATUS_W-1:0] st;
        logic                ev_valid;
        logic [PAGE_W-1:0]   ev_page;
        r = '0;
        if (cmd == CMD_READ)
        begin
            n = cnt;
            if (n > shadow_count)
                n = shadow_count;
            if (n > MAX_RESULTS)
                n = MAX_RESULTS;
            if (n == 0)
            begin
                // empty read still answers once
                r.table_size = SIZE_W'(shadow_count);
                r.last = 1'b1;
                expected_results.push_back(r);
            end
            else
            begin
                for (k = 0; k < n; k++)
                begin
                    r = '0;
                    r.entry_valid = 1'b1;
                    r.entry_rank = RANK_W'(k);
                    r.entry_page = shadow_page[k];
                    r.entry_hotness = shadow_hot[k];
                    r.table_size = SIZE_W'(shadow_count);
                    r.last = (k == n - 1);
                    expected_results.push_back(r);
                end
            end
        end
        else
        begin
            st = ST_DONE;
            ev_valid = 1'b0;
            ev_page = '0;
            if (cmd == CMD_INSERT)
            begin
                shadow_insert(page, hot, st, ev_valid, ev_page);
            end
            else
            begin
                shadow_remove(page, found);
                if (!found)
                    st = ST_NOT_FOUND;
                else if (cmd == CMD_UPDATE)
                    shadow_insert(page, hot, st, ev_valid, ev_page);
            end
            r.status = st;
            r.evicted_valid = ev_valid;
            r.evicted_page = ev_page;
            r.table_size = SIZE_W'(shadow_count);
            r.last = 1'b1;
            expected_results.push_back(r);
        end
    endtask

    // one command transfer: optional idle gap, then valid held until taken
    task automatic send_command(
        input logic [CMD_W-1:0]    cmd,
        input logic [PAGE_W-1:0]   page,
        input logic [HOT_W-1:0]    hot,
        input logic [RCOUNT_W-1:0] cnt
    );
        int gap;
        gap = no_idle ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        page_id <= page;
        hotness <= hot;
        read_count <= cnt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_command(cmd, page, hot, cnt);
    endtask

    task automatic check_field(
        input string       name,
        input logic [63:0] want,
        input logic [63:0] got
    );
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
        end
    endtask

    // receiver: random stalls, released while a burst phase runs
    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold--;
        end
        else if (no_idle || !out_ready)
        begin
            out_ready <= 1'b1;
            ready_hold = no_idle ? 0 : $urandom_range(0, 8);
        end
        else
        begin
            out_ready <= 1'b0;
            ready_hold = pick_gap();
        end
    end

    // each result transfer is compared with the oldest expectation
    always @(posedge clk)
    begin
        tracker_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t ns: unexpected result, expected none, actual status %0h last %0h",
                         $time, status, last);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status", want.status, status);
                check_field("evicted_valid", want.evicted_valid, evicted_valid);
                check_field("evicted_page", want.evicted_page, evicted_page);
                check_field("entry_valid", want.entry_valid, entry_valid);
                check_field("entry_rank", want.entry_rank, entry_rank);
                check_field("entry_page", want.entry_page, entry_page);
                check_field("entry_hotness", want.entry_hotness, entry_hotness);
                check_field("table_size", want.table_size, table_size);
                check_field("last", want.last, last);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // commands against an empty list: empty reads and misses
    task automatic test_empty_table();
        send_command(CMD_READ, '0, '0, RCOUNT_W'(0));
        send_command(CMD_READ, '1, '1, RCOUNT_W'(64));
        send_command(CMD_DELETE, '0, '0, '0);
        send_command(CMD_UPDATE, '1, '1, '0);
    endtask

    // fill to capacity with hotness ties and a duplicate page
    task automatic test_fill_with_ties();
        int                i;
        logic [PAGE_W-1:0] page;
        logic [HOT_W-1:0]  hot;
        for (i = 0; i < TBL_DEPTH; i++)
        begin
            page = rand_page();
            hot = HOT_W'(6 + $urandom_range(0, 900));
            case (i)
                0:
                begin
                    page = '0;
                    hot = '1;
                end
                1:
                begin
                    hot = HOT_W'(1000);
                    dup_page = page;
                end
                2:
                begin
                    // same page, same hotness: newest ranks ahead
                    hot = HOT_W'(1000);
                    page = dup_page;
                end
                3: hot = HOT_W'(1000);
                4: hot = HOT_W'(5);
                15: page = '1;
                default: ;
            endcase
            send_command(CMD_INSERT, page, hot, '0);
        end
    endtask

    // full list: reject, tie eviction, capped read, update and delete of a duplicate
    task automatic test_full_table();
        send_command(CMD_INSERT, rand_page(), '0, '0);
        send_command(CMD_INSERT, rand_page(), HOT_W'(5), '0);
        send_command(CMD_READ, '0, '0, RCOUNT_W'(64));
        send_command(CMD_UPDATE, dup_page, '1, '0);
        send_command(CMD_DELETE, dup_page, '0, '0);
        send_command(CMD_READ, '1, '1, RCOUNT_W'(20));
    endtask

    // random traffic drawn mostly from a small page pool so deletes and updates hit
    task automatic test_random_traffic(
        input int n_items,
        input int ins_pct,
        input int del_pct,
        input int upd_pct,
        input bit burst
    );
        int                i;
        int                r;
        logic [CMD_W-1:0]  cmd;
        logic [PAGE_W-1:0] page;
        no_idle = burst;
        for (i = 0; i < n_items; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < ins_pct)
                cmd = CMD_INSERT;
            else if (r < ins_pct + del_pct)
                cmd = CMD_DELETE;
            else if (r < ins_pct + del_pct + upd_pct)
                cmd = CMD_UPDATE;
            else
                cmd = CMD_READ;
            if ($urandom_range(0, 99) < 75)
                page = page_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                page = rand_page();
            // let the pool drift slowly
            if ($urandom_range(0, 99) < 5)
                page_pool[$urandom_range(0, POOL_SIZE - 1)] = rand_page();
            send_command(cmd, page, rand_hot(), rand_read_count());
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        int p;
        page_pool[0] = '0;
        page_pool[1] = '1;
        for (p = 2; p < POOL_SIZE; p++)
            page_pool[p] = rand_page();

        // reset held, then released on a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_fill_with_ties();
        test_full_table();
        // grow, churn, burst churn without idling, drain, churn again
        test_random_traffic(110, 70, 10, 10, 1'b0);
        test_random_traffic(130, 40, 20, 25, 1'b0);
        test_random_traffic(60, 40, 20, 25, 1'b1);
        test_random_traffic(90, 10, 55, 20, 1'b0);
        test_random_traffic(40, 45, 20, 20, 1'b0);

        // drop valid after the last transfer
        @(negedge clk);
        in_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        // catch any stray result
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
